>>> rtl/rci_pkg.sv
// ----------------------------------------------------------------------------
// rci_pkg
// shared types, constants and arithmetic steps of the ray / cone intersector
// ----------------------------------------------------------------------------
package rci_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int REQ_W      = 192;
   localparam int RSP_W      = 184;

   localparam logic [16:0]        MIN_DIST_RST = 17'((1 << FRAC_BITS) / 100);
   localparam logic [30:0]        T_MAX        = '1;
   localparam logic signed [32:0] ONE_Q        = 33'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] ONE_Q32      = 32'sd1 <<< FRAC_BITS;
   localparam logic [63:0]        CAP_R2       = 64'd1 << (2 * FRAC_BITS);
   localparam logic [15:0]        K_NORM       = 16'd46340;
   localparam logic signed [17:0] NZ_SIDE      = -18'sd46340;
   localparam logic signed [17:0] NZ_CAP       = 18'sd1 <<< FRAC_BITS;

   typedef struct packed {
      logic signed [31:0] dz;
      logic signed [31:0] dy;
      logic signed [31:0] dx;
      logic signed [31:0] oz;
      logic signed [31:0] oy;
      logic signed [31:0] ox;
   } ray_type;

   typedef struct packed {
      logic [63:0] val;
      logic [32:0] rem;
      logic [31:0] root;
   } sqrt_acc_type;

   typedef struct packed {
      logic [32:0]          rem;
      logic [DIV_STEPS-1:0] bits;
      logic [DIV_STEPS-1:0] quo;
   } div_acc_type;

   typedef struct packed {
      ray_type            ray;
      logic signed [31:0] a;
      logic               ok;
      logic signed [33:0] num_lo;
      logic signed [33:0] num_hi;
   } quad_type;

   typedef struct packed {
      logic [30:0]        t;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } cand_type;

   typedef struct packed {
      logic [2:0]       hit;
      cand_type [2:0]   cand;
      logic [1:0][63:0] rsq;
   } root_type;

   typedef struct packed {
      logic               surface;
      logic [30:0]        distance;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [17:0] nx;
      logic signed [17:0] ny;
      logic signed [17:0] nz;
   } hit_type;

   typedef struct packed {
      logic [2:0]    hit;
      hit_type [2:0] res;
   } final_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] m;
      m = v[31] ? 32'(-v) : 32'(v);
      return m;
   endfunction

   function automatic logic [32:0] mag34(input logic signed [33:0] v);
      logic [32:0] m;
      m = v[33] ? 33'(-v) : 33'(v);
      return m;
   endfunction

   // floor-shifted sum of two products minus a third, saturated symmetric
   function automatic logic signed [31:0] sat_sum3(input logic signed [63:0] p0,
                                                   input logic signed [63:0] p1,
                                                   input logic signed [63:0] p2);
      logic signed [63:0] s;
      logic signed [31:0] r;
      s = (p0 >>> FRAC_BITS) + (p1 >>> FRAC_BITS) - (p2 >>> FRAC_BITS);
      if (s > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (s < -64'sd2147483647) begin
         r = 32'sh80000001;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_point(input logic signed [31:0] o,
                                                    input logic signed [63:0] prod);
      logic signed [63:0] s;
      logic signed [31:0] r;
      s = 64'(o) + (prod >>> FRAC_BITS);
      if (s > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (s < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   // one result bit of the digit-by-digit square root
   function automatic sqrt_acc_type sqrt_step(input sqrt_acc_type x);
      sqrt_acc_type y;
      logic [34:0]  r;
      logic [34:0]  trial;
      r      = {x.rem, x.val[63:62]};
      trial  = {1'b0, x.root, 2'b01};
      y.val  = {x.val[61:0], 2'b00};
      if (r >= trial) begin
         r      = r - trial;
         y.root = {x.root[30:0], 1'b1};
      end else begin
         y.root = {x.root[30:0], 1'b0};
      end
      y.rem = r[32:0];
      return y;
   endfunction

   function automatic sqrt_acc_type sqrt_init(input logic [63:0] v);
      sqrt_acc_type y;
      y.val  = v;
      y.rem  = '0;
      y.root = '0;
      return y;
   endfunction

   // numerator magnitude scaled by one, upper part preloaded as remainder
   function automatic div_acc_type div_init(input logic [32:0] m);
      div_acc_type y;
      logic [63:0] n;
      n      = 64'(m) << FRAC_BITS;
      y.rem  = 33'(n >> DIV_STEPS);
      y.bits = n[DIV_STEPS-1:0];
      y.quo  = '0;
      return y;
   endfunction

   // one quotient bit of restoring division
   function automatic div_acc_type div_step(input div_acc_type x, input logic [31:0] d);
      div_acc_type y;
      logic [32:0] r;
      r      = {x.rem[31:0], x.bits[DIV_STEPS-1]};
      y.bits = {x.bits[DIV_STEPS-2:0], 1'b0};
      if (r >= {1'b0, d}) begin
         r     = r - {1'b0, d};
         y.quo = {x.quo[DIV_STEPS-2:0], 1'b1};
      end else begin
         y.quo = {x.quo[DIV_STEPS-2:0], 1'b0};
      end
      y.rem = r;
      return y;
   endfunction

endpackage

>>> rtl/rci_quad.sv
// ----------------------------------------------------------------------------
// rci_quad
// quadratic coefficients, discriminant, its square root and the two numerators
// ----------------------------------------------------------------------------
module rci_quad (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  rci_pkg::ray_type  in_ray,
   output logic              out_valid,
   output rci_pkg::quad_type out_quad
);
   import rci_pkg::*;

   typedef struct packed {
      ray_type            ray;
      logic signed [31:0] a;
      logic signed [31:0] h;
      logic               ok;
      sqrt_acc_type       acc;
   } qside_type;

   logic               v0_ff, v1_ff, v2_ff, v3_ff;
   ray_type            ray0_ff, ray1_ff, ray2_ff, ray3_ff;
   logic signed [63:0] prod_ff [9];
   logic signed [63:0] prod_in [9];
   logic signed [31:0] a2_ff, h2_ff, c2_ff, a2_in, h2_in, c2_in;
   logic signed [31:0] a3_ff, h3_ff;
   logic signed [63:0] hh3_ff, ac3_ff, hh3_in, ac3_in;
   logic [SQRT_STEPS:0] sq_vld_ff;
   qside_type          sq_ff [SQRT_STEPS+1];
   qside_type          sq_in [SQRT_STEPS+1];
   logic signed [63:0] disc;
   logic               disc_ok;
   logic               out_valid_ff;
   quad_type           out_ff, out_in;

   always_comb begin
      prod_in[0] = 64'(ray0_ff.dx) * 64'(ray0_ff.dx);
      prod_in[1] = 64'(ray0_ff.dy) * 64'(ray0_ff.dy);
      prod_in[2] = 64'(ray0_ff.dz) * 64'(ray0_ff.dz);
      prod_in[3] = 64'(ray0_ff.ox) * 64'(ray0_ff.dx);
      prod_in[4] = 64'(ray0_ff.oy) * 64'(ray0_ff.dy);
      prod_in[5] = 64'(ray0_ff.oz) * 64'(ray0_ff.dz);
      prod_in[6] = 64'(ray0_ff.ox) * 64'(ray0_ff.ox);
      prod_in[7] = 64'(ray0_ff.oy) * 64'(ray0_ff.oy);
      prod_in[8] = 64'(ray0_ff.oz) * 64'(ray0_ff.oz);
      a2_in  = sat_sum3(prod_ff[0], prod_ff[1], prod_ff[2]);
      h2_in  = sat_sum3(prod_ff[3], prod_ff[4], prod_ff[5]);
      c2_in  = sat_sum3(prod_ff[6], prod_ff[7], prod_ff[8]);
      hh3_in = 64'(h2_ff) * 64'(h2_ff);
      ac3_in = 64'(a2_ff) * 64'(c2_ff);
      disc    = hh3_ff - ac3_ff;
      disc_ok = (a3_ff != 32'sd0) && !disc[63];
      sq_in[0].ray = ray3_ff;
      sq_in[0].a   = a3_ff;
      sq_in[0].h   = h3_ff;
      sq_in[0].ok  = disc_ok;
      sq_in[0].acc = sqrt_init(disc_ok ? disc : 64'd0);
      for (int i = 1; i <= SQRT_STEPS; i++) begin
         sq_in[i]     = sq_ff[i-1];
         sq_in[i].acc = sqrt_step(sq_ff[i-1].acc);
      end
      out_in.ray    = sq_ff[SQRT_STEPS].ray;
      out_in.a      = sq_ff[SQRT_STEPS].a;
      out_in.ok     = sq_ff[SQRT_STEPS].ok;
      out_in.num_lo = -34'(sq_ff[SQRT_STEPS].h) - $signed({2'b00, sq_ff[SQRT_STEPS].acc.root});
      out_in.num_hi = -34'(sq_ff[SQRT_STEPS].h) + $signed({2'b00, sq_ff[SQRT_STEPS].acc.root});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         sq_vld_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v0_ff        <= in_valid;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         sq_vld_ff    <= {sq_vld_ff[SQRT_STEPS-1:0], v3_ff};
         out_valid_ff <= sq_vld_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ray0_ff <= in_ray;
         ray1_ff <= ray0_ff;
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         ray2_ff <= ray1_ff;
         a2_ff   <= a2_in;
         h2_ff   <= h2_in;
         c2_ff   <= c2_in;
         ray3_ff <= ray2_ff;
         a3_ff   <= a2_ff;
         h3_ff   <= h2_ff;
         hh3_ff  <= hh3_in;
         ac3_ff  <= ac3_in;
         for (int i = 0; i <= SQRT_STEPS; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quad  = out_ff;

endmodule

>>> rtl/rci_root.sv
// ----------------------------------------------------------------------------
// rci_root
// side and cap distances by division, hit points and surface range tests
// ----------------------------------------------------------------------------
module rci_root (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [16:0]       min_distance,
   input  logic              in_valid,
   input  rci_pkg::quad_type in_quad,
   output logic              out_valid,
   output rci_pkg::root_type out_root
);
   import rci_pkg::*;

   typedef struct packed {
      ray_type          ray;
      logic [2:0]       ok;
      logic [2:0]       neg;
      logic [2:0]       sat;
      logic [2:0][31:0] den;
      div_acc_type [2:0] acc;
   } rdiv_type;

   logic [DIV_STEPS:0] dv_vld_ff;
   rdiv_type           dv_ff [DIV_STEPS+1];
   rdiv_type           dv_in [DIV_STEPS+1];
   logic signed [33:0] cap_num;
   logic [32:0]        num_mag [3];

   logic               vt_ff, vm_ff, vp_ff, vs_ff, out_valid_ff;
   ray_type            rayt_ff, raym_ff;
   logic [2:0][30:0]   t_ff, tm_ff, tp_ff, ts_ff, t_in;
   logic [2:0]         okt_ff, okm_ff, okp_ff, okt_in;
   logic signed [63:0] pr_ff [3][3];
   logic signed [63:0] pr_in [3][3];
   logic signed [31:0] pt_ff [3][3];
   logic signed [31:0] pt_in [3][3];
   logic signed [31:0] pts_ff [3][3];
   logic signed [63:0] sq_ff [3][2];
   logic signed [63:0] sq_in [3][2];
   logic [2:0]         flg_ff, flg_in;
   logic [63:0]        rsq [3];
   root_type           out_ff, out_in;

   always_comb begin
      cap_num    = 34'(ONE_Q) - 34'(in_quad.ray.oz);
      num_mag[0] = mag34(in_quad.num_lo);
      num_mag[1] = mag34(in_quad.num_hi);
      num_mag[2] = mag34(cap_num);
      dv_in[0].ray    = in_quad.ray;
      dv_in[0].ok     = {in_quad.ray.dz != 32'sd0, in_quad.ok, in_quad.ok};
      dv_in[0].neg    = {cap_num[33] ^ in_quad.ray.dz[31],
                         in_quad.num_hi[33] ^ in_quad.a[31],
                         in_quad.num_lo[33] ^ in_quad.a[31]};
      dv_in[0].den[0] = mag32(in_quad.a);
      dv_in[0].den[1] = mag32(in_quad.a);
      dv_in[0].den[2] = mag32(in_quad.ray.dz);
      for (int j = 0; j < 3; j++) begin
         dv_in[0].acc[j] = div_init(num_mag[j]);
         dv_in[0].sat[j] = dv_in[0].acc[j].rem >= {1'b0, dv_in[0].den[j]};
      end
      for (int i = 1; i <= DIV_STEPS; i++) begin
         dv_in[i] = dv_ff[i-1];
         for (int j = 0; j < 3; j++) begin
            dv_in[i].acc[j] = div_step(dv_ff[i-1].acc[j], dv_ff[i-1].den[j]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         t_in[j]   = dv_ff[DIV_STEPS].sat[j] ? T_MAX : dv_ff[DIV_STEPS].acc[j].quo;
         okt_in[j] = dv_ff[DIV_STEPS].ok[j] && !dv_ff[DIV_STEPS].neg[j] &&
                     (t_in[j] > 31'(min_distance));
         pr_in[j][0] = 64'(rayt_ff.dx) * 64'($signed({1'b0, t_ff[j]}));
         pr_in[j][1] = 64'(rayt_ff.dy) * 64'($signed({1'b0, t_ff[j]}));
         pr_in[j][2] = 64'(rayt_ff.dz) * 64'($signed({1'b0, t_ff[j]}));
         pt_in[j][0] = sat_point(raym_ff.ox, pr_ff[j][0]);
         pt_in[j][1] = sat_point(raym_ff.oy, pr_ff[j][1]);
         pt_in[j][2] = sat_point(raym_ff.oz, pr_ff[j][2]);
         sq_in[j][0] = 64'(pt_ff[j][0]) * 64'(pt_ff[j][0]);
         sq_in[j][1] = 64'(pt_ff[j][1]) * 64'(pt_ff[j][1]);
         rsq[j]      = $unsigned(sq_ff[j][0]) + $unsigned(sq_ff[j][1]);
      end
      // side needs z within the cone and no apex point
      for (int j = 0; j < 2; j++) begin
         flg_in[j] = okp_ff[j] && !pt_ff[j][2][31] && (pt_ff[j][2] <= ONE_Q32) &&
                     !((pt_ff[j][0] == 32'sd0) && (pt_ff[j][1] == 32'sd0));
      end
      flg_in[2] = okp_ff[2];
      out_in.hit = {flg_ff[2] && (rsq[2] <= CAP_R2), flg_ff[1], flg_ff[0]};
      for (int j = 0; j < 3; j++) begin
         out_in.cand[j].t  = ts_ff[j];
         out_in.cand[j].px = pts_ff[j][0];
         out_in.cand[j].py = pts_ff[j][1];
         out_in.cand[j].pz = pts_ff[j][2];
      end
      out_in.rsq[0] = rsq[0];
      out_in.rsq[1] = rsq[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff    <= '0;
         vt_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         vp_ff        <= 1'b0;
         vs_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         dv_vld_ff    <= {dv_vld_ff[DIV_STEPS-1:0], in_valid};
         vt_ff        <= dv_vld_ff[DIV_STEPS];
         vm_ff        <= vt_ff;
         vp_ff        <= vm_ff;
         vs_ff        <= vp_ff;
         out_valid_ff <= vs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= DIV_STEPS; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         rayt_ff <= dv_ff[DIV_STEPS].ray;
         t_ff    <= t_in;
         okt_ff  <= okt_in;
         raym_ff <= rayt_ff;
         tm_ff   <= t_ff;
         okm_ff  <= okt_ff;
         tp_ff   <= tm_ff;
         okp_ff  <= okm_ff;
         ts_ff   <= tp_ff;
         flg_ff  <= flg_in;
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               pr_ff[j][k]  <= pr_in[j][k];
               pt_ff[j][k]  <= pt_in[j][k];
               pts_ff[j][k] <= pt_ff[j][k];
            end
            sq_ff[j][0] <= sq_in[j][0];
            sq_ff[j][1] <= sq_in[j][1];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_root  = out_ff;

endmodule

>>> rtl/rci_norm.sv
// ----------------------------------------------------------------------------
// rci_norm
// side normals from the radial direction of each hit point, result assembly
// ----------------------------------------------------------------------------
module rci_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  rci_pkg::root_type  in_root,
   output logic               out_valid,
   output rci_pkg::final_type out_res
);
   import rci_pkg::*;

   typedef struct packed {
      logic [2:0]         hit;
      cand_type [2:0]     cand;
      sqrt_acc_type [1:0] acc;
   } nsq_type;

   typedef struct packed {
      logic [2:0]        hit;
      cand_type [2:0]    cand;
      logic [3:0]        neg;
      logic [1:0][31:0]  den;
      div_acc_type [3:0] acc;
   } ndiv_type;

   logic [SQRT_STEPS:0] sq_vld_ff;
   nsq_type             sq_ff [SQRT_STEPS+1];
   nsq_type             sq_in [SQRT_STEPS+1];
   logic [DIV_STEPS:0]  dv_vld_ff;
   ndiv_type            dv_ff [DIV_STEPS+1];
   ndiv_type            dv_in [DIV_STEPS+1];
   logic [32:0]         nprod [4];
   logic signed [17:0]  nval [4];
   logic                out_valid_ff;
   final_type           out_ff, out_in;

   always_comb begin
      sq_in[0].hit    = in_root.hit;
      sq_in[0].cand   = in_root.cand;
      sq_in[0].acc[0] = sqrt_init(in_root.rsq[0]);
      sq_in[0].acc[1] = sqrt_init(in_root.rsq[1]);
      for (int i = 1; i <= SQRT_STEPS; i++) begin
         sq_in[i]        = sq_ff[i-1];
         sq_in[i].acc[0] = sqrt_step(sq_ff[i-1].acc[0]);
         sq_in[i].acc[1] = sqrt_step(sq_ff[i-1].acc[1]);
      end
      dv_in[0].hit  = sq_ff[SQRT_STEPS].hit;
      dv_in[0].cand = sq_ff[SQRT_STEPS].cand;
      for (int j = 0; j < 2; j++) begin
         dv_in[0].den[j]     = sq_ff[SQRT_STEPS].acc[j].root;
         dv_in[0].neg[2*j]   = sq_ff[SQRT_STEPS].cand[j].px[31];
         dv_in[0].neg[2*j+1] = sq_ff[SQRT_STEPS].cand[j].py[31];
         dv_in[0].acc[2*j]   = div_init({1'b0, mag32(sq_ff[SQRT_STEPS].cand[j].px)});
         dv_in[0].acc[2*j+1] = div_init({1'b0, mag32(sq_ff[SQRT_STEPS].cand[j].py)});
      end
      for (int i = 1; i <= DIV_STEPS; i++) begin
         dv_in[i] = dv_ff[i-1];
         for (int q = 0; q < 4; q++) begin
            dv_in[i].acc[q] = div_step(dv_ff[i-1].acc[q], dv_ff[i-1].den[q/2]);
         end
      end
      // unit radial component scaled by 1/sqrt2
      for (int q = 0; q < 4; q++) begin
         nprod[q] = 33'(dv_ff[DIV_STEPS].acc[q].quo[16:0]) * 33'(K_NORM);
         nval[q]  = dv_ff[DIV_STEPS].neg[q] ? -18'($signed({1'b0, nprod[q][32:16]}))
                                             : 18'($signed({1'b0, nprod[q][32:16]}));
      end
      out_in.hit = dv_ff[DIV_STEPS].hit;
      for (int j = 0; j < 3; j++) begin
         out_in.res[j].distance = dv_ff[DIV_STEPS].cand[j].t;
         out_in.res[j].px       = dv_ff[DIV_STEPS].cand[j].px;
         out_in.res[j].py       = dv_ff[DIV_STEPS].cand[j].py;
         out_in.res[j].pz       = dv_ff[DIV_STEPS].cand[j].pz;
      end
      for (int j = 0; j < 2; j++) begin
         out_in.res[j].surface = 1'b0;
         out_in.res[j].nx      = nval[2*j];
         out_in.res[j].ny      = nval[2*j+1];
         out_in.res[j].nz      = NZ_SIDE;
      end
      out_in.res[2].surface = 1'b1;
      out_in.res[2].nx      = '0;
      out_in.res[2].ny      = '0;
      out_in.res[2].nz      = NZ_CAP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff    <= '0;
         dv_vld_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_vld_ff    <= {sq_vld_ff[SQRT_STEPS-1:0], in_valid};
         dv_vld_ff    <= {dv_vld_ff[DIV_STEPS-1:0], sq_vld_ff[SQRT_STEPS]};
         out_valid_ff <= dv_vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= SQRT_STEPS; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         for (int i = 0; i <= DIV_STEPS; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;

endmodule

>>> rtl/rci_emit.sv
// ----------------------------------------------------------------------------
// rci_emit
// output slot that sends the hits of one ray as consecutive words, or one miss word if none
// ----------------------------------------------------------------------------
module rci_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rci_pkg::final_type in_res,
   output logic               advance,
   output logic               out_valid,
   input  logic               out_ready,
   output rci_pkg::hit_type   out_word,
   output logic               out_hit,
   output logic               out_last
);
   import rci_pkg::*;

   logic      slot_vld_ff;
   logic [2:0] mask_ff;
   final_type slot_ff;
   logic [2:0] rest;
   hit_type   cur;
   logic      cur_hit;

   always_comb begin
      cur     = '0;
      cur_hit = 1'b0;
      rest    = '0;
      priority if (mask_ff[0]) begin
         cur     = slot_ff.res[0];
         cur_hit = 1'b1;
         rest    = {mask_ff[2:1], 1'b0};
      end else if (mask_ff[1]) begin
         cur     = slot_ff.res[1];
         cur_hit = 1'b1;
         rest    = {mask_ff[2], 2'b00};
      end else if (mask_ff[2]) begin
         cur     = slot_ff.res[2];
         cur_hit = 1'b1;
      end
   end

   assign out_last  = (rest == 3'b000);
   assign advance   = !slot_vld_ff || (out_ready && out_last);
   assign out_valid = slot_vld_ff;
   assign out_word  = cur;
   assign out_hit   = cur_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= 1'b0;
         mask_ff     <= '0;
      end else if (advance) begin
         slot_vld_ff <= in_valid;
         mask_ff     <= in_res.hit;
      end else if (out_ready) begin
         mask_ff <= rest;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= in_res;
      end
   end

endmodule

>>> rtl/ray_cone_intersect.sv
// ----------------------------------------------------------------------------
// ray_cone_intersect
// ray against capped unit cone, Q16.16 fixed point, up to three hits per ray
// ----------------------------------------------------------------------------
// a ray word enters in any cycle the pipeline is not held. each ray gives
// one to three result words (the side hit from -h - sqrt(disc), then the one
// from -h + sqrt(disc), then the cap), the last one flagged with tlast, and
// holds the whole pipeline until its last word is taken, so throughput is
// one ray per cycle for single-result rays while rsp_tready stays high, and
// lower for rays with more words or a stalled rsp_tready. the depth is set by
// the two 32-step square roots and two 31-step dividers laid out one step per stage.
module ray_cone_intersect (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, 3 pad
   output logic [183:0] rsp_tdata,
   // hit, surface
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [16:0]  csr_wr_data
);
   import rci_pkg::*;

   logic [16:0] min_ff, min_in;
   logic        advance;
   logic        quad_vld, root_vld, norm_vld;
   quad_type    quad;
   root_type    root;
   final_type   fin;
   hit_type     word;
   logic        word_hit;

   assign min_in = csr_wr_en ? csr_wr_data : min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_DIST_RST;
      end else begin
         min_ff <= min_in;
      end
   end

   assign req_tready = advance;

   rci_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_ray    (ray_type'(req_tdata)),
      .out_valid (quad_vld),
      .out_quad  (quad)
   );

   rci_root u_root (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .min_distance (min_ff),
      .in_valid     (quad_vld),
      .in_quad      (quad),
      .out_valid    (root_vld),
      .out_root     (root)
   );

   rci_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (root_vld),
      .in_root   (root),
      .out_valid (norm_vld),
      .out_res   (fin)
   );

   rci_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_vld),
      .in_res    (fin),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (word),
      .out_hit   (word_hit),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, word.nz, word.ny, word.nx, word.pz, word.py, word.px,
                       word.distance};
   assign rsp_tuser = {word.surface, word_hit};

endmodule

>>> verif/ray_cone_intersect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_cone_intersect_tb
// self-checking bench for the ray / capped cone intersector: a directed table
// of rays, then random rays aimed at the cone mixed with raw noise, each
// checked word by word against a fixed-point intersection predictor, under
// random idling on both streams and several min distance settings
// ----------------------------------------------------------------------------
module ray_cone_intersect_tb;
   import rci_pkg::*;

   localparam longint QONE   = 64'sd1 <<< FRAC_BITS;
   localparam longint TLIMIT = 64'sd2147483647;
   localparam int     DRAIN  = 200;

   typedef struct {
      logic               hit;
      logic               surface;
      logic [30:0]        distance;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [17:0] nx;
      logic signed [17:0] ny;
      logic signed [17:0] nz;
      logic               last;
   } hit_word_type;

   typedef struct {
      ray_type ray;
      int      typed;   // 0 predictor, 1 no hit, 2 cap only at (0,0,1) t=1
   } ray_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en;
   logic [16:0]  csr_wr_data;

   hit_word_type expected_hits[$];
   longint       min_dist_q;
   int           error_count;
   int           rays_sent;
   int           words_seen;
   int           side_hits;
   int           cap_hits;
   int           misses;
   bit           steady;
   bit           hold_req;
   int           hold_left;

   ray_cone_intersect i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("timeout with %0d words still expected", expected_hits.size());
      $display("ray_cone_intersect_tb: FAIL");
      $finish;
   end

   // ---------------- predictor ----------------

   function automatic void queue_word(input hit_word_type w);
      expected_hits.insert(expected_hits.size(), w);
   endfunction

   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned absq(input longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint divq(input longint num, input longint den);
      longint unsigned q;
      q = (absq(num) << FRAC_BITS) / absq(den);
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clip_sym(input longint v);
      if (v > TLIMIT) return TLIMIT;
      if (v < -TLIMIT) return -TLIMIT;
      return v;
   endfunction

   function automatic longint clip32(input longint v);
      if (v > TLIMIT) return TLIMIT;
      if (v < -TLIMIT - 1) return -TLIMIT - 1;
      return v;
   endfunction

   function automatic void point_at(input longint o[3], input longint d[3], input longint t,
                                    output longint p[3]);
      for (int i = 0; i < 3; i++) p[i] = clip32(o[i] + ((d[i] * t) >>> FRAC_BITS));
   endfunction

   function automatic void push_hit(input bit surf, input longint t, input longint p[3],
                                    input longint n[3]);
      hit_word_type w;
      w.hit      = 1'b1;
      w.surface  = surf;
      w.distance = t[30:0];
      w.px       = p[0][31:0];
      w.py       = p[1][31:0];
      w.pz       = p[2][31:0];
      w.nx       = n[0][17:0];
      w.ny       = n[1][17:0];
      w.nz       = n[2][17:0];
      w.last     = 1'b0;
      queue_word(w);
   endfunction

   function automatic int side_root(input longint num, input longint a, input longint o[3],
                                    input longint d[3]);
      longint t, r, k, ux, uy;
      longint p[3];
      longint n[3];
      t = divq(num, a);
      if (t > TLIMIT) t = TLIMIT;
      if (t <= min_dist_q) return 0;
      point_at(o, d, t, p);
      if (p[2] < 0 || p[2] > QONE) return 0;
      if (p[0] == 0 && p[1] == 0) return 0;
      r  = isqrt(longint'(p[0] * p[0]) + longint'(p[1] * p[1]));
      ux = divq(p[0], r);
      uy = divq(p[1], r);
      k  = isqrt(64'd1 << (2 * FRAC_BITS - 1));
      n[0] = ((ux < 0) ? -longint'(absq(ux) * k >> FRAC_BITS) : (ux * k) >>> FRAC_BITS);
      n[1] = ((uy < 0) ? -longint'(absq(uy) * k >> FRAC_BITS) : (uy * k) >>> FRAC_BITS);
      n[2] = -k;
      push_hit(1'b0, t, p, n);
      return 1;
   endfunction

   function automatic void predict_hits(input ray_type ray);
      longint o[3];
      longint d[3];
      longint p[3];
      longint n[3];
      longint a, h, c, disc, s, t;
      int     cnt;
      hit_word_type w;
      o[0] = ray.ox; o[1] = ray.oy; o[2] = ray.oz;
      d[0] = ray.dx; d[1] = ray.dy; d[2] = ray.dz;
      cnt = 0;
      a = clip_sym(((d[0] * d[0]) >>> FRAC_BITS) + ((d[1] * d[1]) >>> FRAC_BITS)
                   - ((d[2] * d[2]) >>> FRAC_BITS));
      h = clip_sym(((o[0] * d[0]) >>> FRAC_BITS) + ((o[1] * d[1]) >>> FRAC_BITS)
                   - ((o[2] * d[2]) >>> FRAC_BITS));
      c = clip_sym(((o[0] * o[0]) >>> FRAC_BITS) + ((o[1] * o[1]) >>> FRAC_BITS)
                   - ((o[2] * o[2]) >>> FRAC_BITS));
      if (a != 0) begin
         disc = h * h - a * c;
         if (disc >= 0) begin
            s = isqrt(disc);
            cnt += side_root(-h - s, a, o, d);
            cnt += side_root(-h + s, a, o, d);
         end
      end
      if (d[2] != 0) begin
         t = divq(QONE - o[2], d[2]);
         if (t > TLIMIT) t = TLIMIT;
         if (t > min_dist_q) begin
            point_at(o, d, t, p);
            if ($unsigned(p[0] * p[0]) + $unsigned(p[1] * p[1])
                <= (64'd1 << (2 * FRAC_BITS))) begin
               n[0] = 0; n[1] = 0; n[2] = QONE;
               push_hit(1'b1, t, p, n);
               cnt++;
            end
         end
      end
      if (cnt == 0) begin
         w = '{default: '0};
         w.last = 1'b1;
         queue_word(w);
      end else begin
         expected_hits[expected_hits.size() - 1].last = 1'b1;
      end
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_word();
      hit_word_type w;
      hit_word_type g;
      g.distance = rsp_tdata[30:0];
      g.px       = rsp_tdata[62:31];
      g.py       = rsp_tdata[94:63];
      g.pz       = rsp_tdata[126:95];
      g.nx       = rsp_tdata[144:127];
      g.ny       = rsp_tdata[162:145];
      g.nz       = rsp_tdata[180:163];
      g.hit      = rsp_tuser[0];
      g.surface  = rsp_tuser[1];
      g.last     = rsp_tlast;
      words_seen++;
      if (expected_hits.size() == 0) begin
         report_mismatch("unexpected word, hit", g.hit, 0);
         return;
      end
      w = expected_hits.pop_front();
      if (w.hit && !w.surface) side_hits++;
      if (w.hit && w.surface) cap_hits++;
      if (!w.hit) misses++;
      if (g.hit !== w.hit)           report_mismatch("hit", g.hit, w.hit);
      if (g.surface !== w.surface)   report_mismatch("surface", g.surface, w.surface);
      if (g.distance !== w.distance) report_mismatch("distance", g.distance, w.distance);
      if (g.px !== w.px)             report_mismatch("point_x", g.px, w.px);
      if (g.py !== w.py)             report_mismatch("point_y", g.py, w.py);
      if (g.pz !== w.pz)             report_mismatch("point_z", g.pz, w.pz);
      if (g.nx !== w.nx)             report_mismatch("normal_x", g.nx, w.nx);
      if (g.ny !== w.ny)             report_mismatch("normal_y", g.ny, w.ny);
      if (g.nz !== w.nz)             report_mismatch("normal_z", g.nz, w.nz);
      if (g.last !== w.last)         report_mismatch("last", g.last, w.last);
   endtask

   // result side: random stalls, a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_word();
         if (hold_req && hold_left == 0) begin
            hold_left  <= 400;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= (hold_left == 1);
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 22);
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic send_ray(input ray_type ray, input int typed);
      hit_word_type w;
      while (!steady && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ray;
      do @(posedge clock); while (!req_tready);
      rays_sent++;
      if (typed == 0) begin
         predict_hits(ray);
      end else if (typed == 1) begin
         w = '{default: '0};
         w.last = 1'b1;
         queue_word(w);
      end else begin
         w = '{default: '0};
         w.hit = 1'b1; w.surface = 1'b1; w.distance = 31'(QONE);
         w.pz = ONE_Q32; w.nz = NZ_CAP; w.last = 1'b1;
         queue_word(w);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic write_min_dist(input logic [16:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      min_dist_q  = v;
   endtask

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      int tx, ty, tz, sh;
      if ($urandom_range(99) < 20) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         tx = pick(-78643, 78643);
         ty = pick(-78643, 78643);
         tz = pick(-13107, 78643);
         r.ox = pick(-196608, 196608);
         r.oy = pick(-196608, 196608);
         r.oz = pick(-131072, 196608);
         sh = $urandom_range(3);
         r.dx = (tx - r.ox) <<< sh >>> 1;
         r.dy = (ty - r.oy) <<< sh >>> 1;
         r.dz = (tz - r.oz) <<< sh >>> 1;
      end
      return r;
   endfunction

   ray_row_type directed[$];

   function automatic void add_row(input ray_type ray, input int typed);
      ray_row_type row;
      row.ray   = ray;
      row.typed = typed;
      directed.insert(directed.size(), row);
   endfunction

   initial begin
      ray_type r;
      logic [16:0] settings[4];
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      hold_req    = 1'b0;
      steady      = 1'b0;
      min_dist_q  = MIN_DIST_RST;
      error_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero ray, straight down the axis, parallel miss, extremes, cone grazes
      add_row('{default: 0}, 1);
      add_row('{dz: -ONE_Q32, oz: 2 * ONE_Q32, default: 0}, 2);
      add_row('{dx: ONE_Q32, ox: 5 * ONE_Q32, oy: 5 * ONE_Q32, oz: 5 * ONE_Q32,
                default: 0}, 1);
      add_row('{default: 32'sh7fffffff}, 0);
      add_row('{default: 32'sh80000000}, 0);
      add_row('{ox: 32'sh7fffffff, oy: 32'sh80000000, oz: 0,
                dx: 32'sh80000000, dy: 32'sh7fffffff, dz: 1}, 0);
      add_row('{ox: -2 * ONE_Q32, oy: 0, oz: ONE_Q32 / 2, dx: ONE_Q32, dy: 0, dz: 0}, 0);
      add_row('{ox: 0, oy: -2 * ONE_Q32, oz: -ONE_Q32, dx: 0, dy: ONE_Q32, dz: ONE_Q32}, 0);
      add_row('{ox: ONE_Q32 / 4, oy: ONE_Q32 / 4, oz: 2 * ONE_Q32, dx: 0, dy: 0,
                dz: -ONE_Q32}, 0);
      add_row('{ox: 0, oy: 0, oz: -ONE_Q32, dx: ONE_Q32, dy: 0, dz: ONE_Q32}, 0);
      add_row('{ox: ONE_Q32, oy: 0, oz: 0, dx: -ONE_Q32, dy: 0, dz: ONE_Q32}, 0);
      add_row('{ox: -ONE_Q32, oy: -ONE_Q32, oz: -ONE_Q32, dx: 1, dy: 1, dz: 1}, 0);
      add_row('{ox: 3 * ONE_Q32, oy: 0, oz: ONE_Q32 / 2, dx: -1, dy: 0, dz: 0}, 0);
      add_row('{ox: 0, oy: ONE_Q32 / 2, oz: ONE_Q32 / 2, dx: 0, dy: 0, dz: 0}, 0);
      add_row('{ox: ONE_Q32 / 2, oy: 0, oz: ONE_Q32 / 2, dx: 0, dy: ONE_Q32, dz: 0}, 0);
      foreach (directed[i]) send_ray(directed[i].ray, directed[i].typed);

      settings[0] = 17'd0;
      settings[1] = 17'h10000;
      settings[2] = 17'($urandom_range(65536));
      settings[3] = MIN_DIST_RST;
      for (int ph = 0; ph < 4; ph++) begin
         write_min_dist(settings[ph]);
         steady = (ph == 3);
         for (int i = 0; i < 68; i++) begin
            if (ph == 1 && i == 20) begin
               req_tvalid <= 1'b0;
               hold_req   <= 1'b1;
               @(posedge clock);
               hold_req <= 1'b0;
            end
            if (ph == 2 && i == 30) begin
               req_tvalid <= 1'b0;
               do @(posedge clock); while (expected_hits.size() != 0);
            end
            r = random_ray();
            send_ray(r, 0);
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("rays sent %0d, words checked %0d: %0d side hits, %0d cap hits, %0d misses",
               rays_sent, words_seen, side_hits, cap_hits, misses);
      $display("min distance settings 0, 65536, %0d, %0d; %0d mismatches",
               settings[2], settings[3], error_count);
      if (error_count == 0) begin
         $display("ray_cone_intersect_tb: PASS");
      end else begin
         $display("ray_cone_intersect_tb: FAIL");
      end
      $finish;
   end

endmodule
